// ----- hdl/keypad_frequency_entry_top_assert.svh -----
// Assertion macros for the keypad frequency-entry block.
// Used by keypad_frequency_entry_top; needs nothing else.
`ifndef KEYPAD_FREQUENCY_ENTRY_TOP_ASSERT_SVH
`define KEYPAD_FREQUENCY_ENTRY_TOP_ASSERT_SVH

// Same-cycle implication, masked during reset.
`define KFE_ASSERT_NOW(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("kfe: same-cycle check failed");

// Next-cycle implication, masked during reset.
`define KFE_ASSERT_NEXT(label, clk, rstn, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("kfe: next-cycle check failed");

`endif

// ----- hdl/kfe_pkg.sv -----
// Shared types, codes and arithmetic helpers for the keypad frequency-entry block.
// No dependencies; imported by kfe_cfg, kfe_ctrl and keypad_frequency_entry_top.
`default_nettype none

package kfe_pkg;

    localparam int MAX_CHARS_DEF = 12;
    localparam int APB_ADDR_W    = 4;

    // register indexes (byte address = 4 * index)
    localparam logic [1:0] REG_TIMEOUT = 2'd0;
    localparam logic [1:0] REG_MIN     = 2'd1;
    localparam logic [1:0] REG_MAX     = 2'd2;

    localparam logic [7:0]  TIMEOUT_RST = 8'd10;
    localparam logic [31:0] MIN_RST     = 32'd100000;
    localparam logic [31:0] MAX_RST     = 32'd500000000;

    localparam logic [7:0] KEY_HASH = 8'h23;
    localparam logic [7:0] KEY_STAR = 8'h2A;
    localparam logic [7:0] KEY_D    = 8'h44;
    localparam logic [7:0] KEY_ZERO = 8'h30;
    localparam logic [7:0] KEY_NINE = 8'h39;

    localparam logic [1:0] VFO_A      = 2'd0;
    localparam logic [1:0] VFO_B      = 2'd1;
    localparam logic [1:0] VFO_ACTIVE = 2'd2;

    // clamped accumulator: bit 32 set means "at least 2^32"
    localparam logic [32:0] ACC_OVER = {1'b1, 32'd0};

    typedef enum logic [1:0] {
        MODE_IDLE   = 2'd0,
        MODE_SELECT = 2'd1,
        MODE_ENTER  = 2'd2
    } mode_t;

    typedef enum logic [2:0] {
        REQ_KEY    = 3'd0,
        REQ_TICK   = 3'd1,
        REQ_RADIO  = 3'd2,
        REQ_CANCEL = 3'd3,
        REQ_ARM    = 3'd4
    } req_t;

    typedef enum logic [3:0] {
        EV_NONE       = 4'd0,
        EV_MODE       = 4'd1,
        EV_VFO        = 4'd2,
        EV_DIGIT      = 4'd3,
        EV_POINT      = 4'd4,
        EV_CANCEL     = 4'd5,
        EV_TIMEOUT    = 4'd6,
        EV_INVALID    = 4'd7,
        EV_SET        = 4'd8,
        EV_ANNOUNCE   = 4'd9,
        EV_SUPPRESSED = 4'd10
    } ev_t;

    typedef struct packed {
        logic [7:0]  timeout_seconds;
        logic [31:0] min_freq_hz;
        logic [31:0] max_freq_hz;
    } cfg_t;

    typedef struct packed {
        logic [2:0]  req_type;
        logic [7:0]  key;
        logic [31:0] new_freq_hz;
        logic        verbosity_on;
    } item_t;

    typedef struct packed {
        logic        consumed;
        ev_t         event_res;
        logic [3:0]  digit;
        logic [1:0]  vfo;
        logic [31:0] freq_hz;
    } result_t;

    // acc * 10 + addend, clamped at ACC_OVER
    function automatic logic [32:0] acc_scale_add(input logic [32:0] acc,
                                                  input logic [31:0] addend);
        logic [36:0] wide;
        wide = ({5'd0, acc[31:0]} << 3) + ({5'd0, acc[31:0]} << 1) + {5'd0, addend};
        if (acc[32] || (wide[36:32] != 5'd0)) begin
            return ACC_OVER;
        end
        return {1'b0, wide[31:0]};
    endfunction

    // acc + addend, clamped at ACC_OVER
    function automatic logic [32:0] acc_add(input logic [32:0] acc,
                                            input logic [19:0] addend);
        logic [32:0] sum;
        sum = {1'b0, acc[31:0]} + {13'd0, addend};
        if (acc[32] || sum[32]) begin
            return ACC_OVER;
        end
        return sum;
    endfunction

    function automatic logic [19:0] place_hz(input logic [2:0] pos);
        logic [19:0] w;
        case (pos)
            3'd0:    w = 20'd100000;
            3'd1:    w = 20'd10000;
            3'd2:    w = 20'd1000;
            3'd3:    w = 20'd100;
            3'd4:    w = 20'd10;
            default: w = 20'd1;
        endcase
        return w;
    endfunction

    function automatic logic [19:0] frac_weight(input logic [3:0] d, input logic [2:0] pos);
        return 20'({20'd0, d} * {4'd0, place_hz(pos)});
    endfunction

    function automatic logic [31:0] digit_mhz(input logic [3:0] d);
        return {28'd0, d} * 32'd1000000;
    endfunction

    function automatic logic [31:0] digit_khz(input logic [3:0] d);
        return {28'd0, d} * 32'd1000;
    endfunction

endpackage

`default_nettype wire

// ----- hdl/kfe_cfg.sv -----
// APB register file: timeout and frequency range limits.
// Depends on kfe_pkg.
`default_nettype none

module kfe_cfg (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kfe_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output      logic [31:0]                     prdata,
    output      logic                            pready,
    output      kfe_pkg::cfg_t                   cfg
);
    import kfe_pkg::*;

    cfg_t       cfg_reg;
    cfg_t       cfg_next;
    logic       wr_en;
    logic [1:0] reg_idx;

    assign pready  = 1'b1;
    assign wr_en   = psel && penable && pwrite && pready;
    assign reg_idx = paddr[3:2];

    always_comb begin
        cfg_next = cfg_reg;
        if (wr_en) begin
            unique case (reg_idx)
                REG_TIMEOUT: cfg_next.timeout_seconds = pwdata[7:0];
                REG_MIN:     cfg_next.min_freq_hz     = pwdata;
                REG_MAX:     cfg_next.max_freq_hz     = pwdata;
                default:     ;
            endcase
        end
    end

    always_comb begin
        unique case (reg_idx)
            REG_TIMEOUT: prdata = {24'd0, cfg_reg.timeout_seconds};
            REG_MIN:     prdata = cfg_reg.min_freq_hz;
            REG_MAX:     prdata = cfg_reg.max_freq_hz;
            default:     prdata = 32'd0;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cfg_reg.timeout_seconds <= TIMEOUT_RST;
            cfg_reg.min_freq_hz     <= MIN_RST;
            cfg_reg.max_freq_hz     <= MAX_RST;
        end else begin
            cfg_reg <= cfg_next;
        end
    end

    assign cfg = cfg_reg;

endmodule

`default_nettype wire

// ----- hdl/kfe_ctrl.sv -----
// Entry state machine and clamped frequency accumulators; one transaction per call.
// Depends on kfe_pkg; driven by keypad_frequency_entry_top.
`default_nettype none

module kfe_ctrl #(
    parameter int MAX_CHARS = kfe_pkg::MAX_CHARS_DEF
) (
    input  wire logic             aclk,
    input  wire logic             aresetn,
    input  wire logic             item_en,
    input  wire kfe_pkg::item_t   item,
    input  wire kfe_pkg::cfg_t    cfg,
    output      kfe_pkg::result_t result
);
    import kfe_pkg::*;

    localparam int               LEN_W   = $clog2(MAX_CHARS + 1);
    localparam logic [LEN_W-1:0] LEN_MAX = LEN_W'(MAX_CHARS);

    mode_t             mode_reg,  mode_next;
    logic [1:0]        vfo_reg,   vfo_next;
    logic [LEN_W-1:0]  len_reg,   len_next;
    logic              point_reg, point_next;
    logic [32:0]       khz_reg,   khz_next;   // whole part * 1000, clamped
    logic [32:0]       mhz_reg,   mhz_next;   // whole * 1e6 + fraction, clamped
    logic [2:0]        fd_reg,    fd_next;
    logic              subhz_reg, subhz_next;
    logic [7:0]        idle_reg,  idle_next;
    logic              supp_reg,  supp_next;

    logic        busy, key_digit, key_hash, key_star, key_d;
    logic [3:0]  key_val;
    logic        timeout_hit, len_full, khz_mode, eval_frac, eval_ok;
    logic [32:0] eval_val;
    logic        push, clear;

    assign busy        = (mode_reg != MODE_IDLE);
    assign key_digit   = (item.key >= KEY_ZERO) && (item.key <= KEY_NINE);
    assign key_hash    = (item.key == KEY_HASH);
    assign key_star    = (item.key == KEY_STAR);
    assign key_d       = (item.key == KEY_D);
    assign key_val     = item.key[3:0];
    assign timeout_hit = busy && (idle_reg > cfg.timeout_seconds);
    assign len_full    = (len_reg >= LEN_MAX);

    // four or five bare digits are kHz, anything else MHz
    assign khz_mode  = !point_reg && ((len_reg == LEN_W'(4)) || (len_reg == LEN_W'(5)));
    assign eval_val  = khz_mode ? khz_reg : mhz_reg;
    assign eval_frac = !khz_mode && subhz_reg;
    assign eval_ok   = (len_reg != '0)
                    && !(eval_val < {1'b0, cfg.min_freq_hz})
                    && !(eval_val > {1'b0, cfg.max_freq_hz})
                    && !((eval_val == {1'b0, cfg.max_freq_hz}) && eval_frac);

    // next mode
    always_comb begin
        mode_next = mode_reg;
        if (item_en) begin
            unique case (item.req_type)
                REQ_KEY: begin
                    if (timeout_hit) begin
                        mode_next = MODE_IDLE;
                    end else begin
                        unique case (mode_reg)
                            MODE_IDLE: begin
                                if (key_hash) mode_next = MODE_SELECT;
                            end
                            MODE_SELECT: begin
                                if (!key_hash && key_digit) begin
                                    mode_next = MODE_ENTER;
                                end else if (!key_hash && (key_star || key_d)) begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                            MODE_ENTER: begin
                                if ((key_star && point_reg) || key_hash || key_d) begin
                                    mode_next = MODE_IDLE;
                                end
                            end
                            default: mode_next = MODE_IDLE;
                        endcase
                    end
                end
                REQ_CANCEL: mode_next = MODE_IDLE;
                default:    ;
            endcase
        end
    end

    // datapath and result
    always_comb begin
        vfo_next   = vfo_reg;
        len_next   = len_reg;
        point_next = point_reg;
        khz_next   = khz_reg;
        mhz_next   = mhz_reg;
        fd_next    = fd_reg;
        subhz_next = subhz_reg;
        idle_next  = idle_reg;
        supp_next  = supp_reg;
        push       = 1'b0;
        clear      = 1'b0;

        result.consumed  = 1'b0;
        result.event_res = EV_NONE;
        result.digit     = 4'd0;
        result.freq_hz   = 32'd0;

        if (item_en) begin
            unique case (item.req_type)
                REQ_KEY: begin
                    result.consumed = 1'b1;
                    if (timeout_hit) begin
                        clear            = 1'b1;
                        result.event_res = EV_TIMEOUT;
                    end else begin
                        idle_next = 8'd0;
                        case (mode_reg)
                            MODE_IDLE: begin
                                if (key_hash) begin
                                    result.event_res = EV_MODE;
                                end else begin
                                    result.consumed = 1'b0;
                                end
                            end
                            MODE_SELECT: begin
                                if (key_hash) begin
                                    vfo_next         = (vfo_reg == VFO_ACTIVE) ? VFO_A
                                                                               : vfo_reg + 2'd1;
                                    result.event_res = EV_VFO;
                                end else if (key_digit) begin
                                    push             = 1'b1;
                                    result.event_res = EV_DIGIT;
                                    result.digit     = key_val;
                                end else if (key_star || key_d) begin
                                    clear            = 1'b1;
                                    result.event_res = EV_CANCEL;
                                end
                            end
                            MODE_ENTER: begin
                                if (key_digit) begin
                                    if (!len_full) begin
                                        push             = 1'b1;
                                        result.event_res = EV_DIGIT;
                                        result.digit     = key_val;
                                    end
                                end else if (key_star) begin
                                    if (point_reg) begin
                                        clear            = 1'b1;
                                        result.event_res = EV_CANCEL;
                                    end else if (!len_full) begin
                                        point_next       = 1'b1;
                                        len_next         = len_reg + LEN_W'(1);
                                        result.event_res = EV_POINT;
                                    end
                                end else if (key_hash) begin
                                    clear = 1'b1;
                                    if (eval_ok) begin
                                        supp_next        = 1'b1;
                                        result.event_res = EV_SET;
                                        result.freq_hz   = eval_val[31:0];
                                    end else begin
                                        result.event_res = EV_INVALID;
                                    end
                                end else if (key_d) begin
                                    clear            = 1'b1;
                                    result.event_res = EV_CANCEL;
                                end
                            end
                            default: ;
                        endcase
                    end
                end
                REQ_TICK: begin
                    if (busy && (idle_reg != 8'hFF)) idle_next = idle_reg + 8'd1;
                end
                REQ_RADIO: begin
                    if (!busy) begin
                        if (supp_reg) begin
                            supp_next        = 1'b0;
                            result.event_res = EV_SUPPRESSED;
                        end else if (item.verbosity_on) begin
                            result.event_res = EV_ANNOUNCE;
                            result.freq_hz   = item.new_freq_hz;
                        end
                    end
                end
                REQ_CANCEL: begin
                    if (busy) begin
                        clear            = 1'b1;
                        result.event_res = EV_CANCEL;
                    end
                end
                REQ_ARM: supp_next = 1'b1;
                default: ;
            endcase
        end

        if (push) begin
            if (!point_reg) begin
                khz_next = acc_scale_add(khz_reg, digit_khz(key_val));
                mhz_next = acc_scale_add(mhz_reg, digit_mhz(key_val));
            end else if (fd_reg < 3'd6) begin
                mhz_next = acc_add(mhz_reg, frac_weight(key_val, fd_reg));
                fd_next  = fd_reg + 3'd1;
            end else if (key_val != 4'd0) begin
                subhz_next = 1'b1;
            end
            len_next = len_reg + LEN_W'(1);
        end

        if (clear) begin
            len_next   = '0;
            point_next = 1'b0;
            khz_next   = 33'd0;
            mhz_next   = 33'd0;
            fd_next    = 3'd0;
            subhz_next = 1'b0;
            idle_next  = 8'd0;
        end

        result.vfo = vfo_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            mode_reg  <= MODE_IDLE;
            vfo_reg   <= VFO_ACTIVE;
            len_reg   <= '0;
            point_reg <= 1'b0;
            khz_reg   <= 33'd0;
            mhz_reg   <= 33'd0;
            fd_reg    <= 3'd0;
            subhz_reg <= 1'b0;
            idle_reg  <= 8'd0;
            supp_reg  <= 1'b0;
        end else begin
            mode_reg  <= mode_next;
            vfo_reg   <= vfo_next;
            len_reg   <= len_next;
            point_reg <= point_next;
            khz_reg   <= khz_next;
            mhz_reg   <= mhz_next;
            fd_reg    <= fd_next;
            subhz_reg <= subhz_next;
            idle_reg  <= idle_next;
            supp_reg  <= supp_next;
        end
    end

endmodule

`default_nettype wire

// ----- hdl/keypad_frequency_entry_top.sv -----
// Keypad frequency-entry controller, top level. Depends on kfe_pkg, kfe_cfg, kfe_ctrl.
// Path: a transaction taken on s_axis is held in the input register, then passes
//   through single-pass logic into the result register that drives m_axis.
// Throughput: one transaction per cycle while m_axis_tready holds; state feedback is one register deep.
// Reset: synchronous, active low; empties both registers, mode idle, VFO current,
//   timeout 10 s, range 100 kHz to 500 MHz.
`default_nettype none

`include "keypad_frequency_entry_top_assert.svh"

module keypad_frequency_entry_top #(
    parameter int MAX_CHARS = kfe_pkg::MAX_CHARS_DEF   // entry length incl. point
) (
    input  wire logic                            aclk,
    input  wire logic                            aresetn,
    // input stream
    input  wire logic                            s_axis_tvalid,
    output      logic                            s_axis_tready,
    input  wire logic [47:0]                     s_axis_tdata,  // key[7:0], new_freq_hz[39:8],
                                                                // verbosity_on[40], zero pad
    input  wire logic [2:0]                      s_axis_tuser,  // req_type[2:0]
    // result stream
    output      logic                            m_axis_tvalid,
    input  wire logic                            m_axis_tready,
    output      logic [39:0]                     m_axis_tdata,  // consumed[0], digit[4:1],
                                                                // vfo[6:5], freq_hz[38:7], pad
    output      logic [3:0]                      m_axis_tuser,  // event_res[3:0]
    // configuration
    input  wire logic                            psel,
    input  wire logic                            penable,
    input  wire logic                            pwrite,
    input  wire logic [kfe_pkg::APB_ADDR_W-1:0]  paddr,
    input  wire logic [31:0]                     pwdata,
    output      logic [31:0]                     prdata,
    output      logic                            pready
);
    import kfe_pkg::*;

    cfg_t    cfg;
    item_t   in_item_reg, in_item_next;
    logic    in_valid_reg, in_valid_next;
    result_t out_reg, out_next;
    logic    out_valid_reg, out_valid_next;
    result_t step_res;
    logic    s_take, advance, proc;

    // ---------------------------------------------------------------
    // Handshake: the result register frees when empty or being taken;
    // the input register accepts when empty or when its item moves on that cycle.
    // ---------------------------------------------------------------
    assign advance       = !out_valid_reg || m_axis_tready;
    assign proc          = in_valid_reg && advance;
    assign s_axis_tready = !in_valid_reg || advance;
    assign s_take        = s_axis_tvalid && s_axis_tready;

    always_comb begin
        in_item_next  = in_item_reg;
        in_valid_next = in_valid_reg;
        if (s_take) begin
            in_item_next.req_type     = s_axis_tuser;
            in_item_next.key          = s_axis_tdata[7:0];
            in_item_next.new_freq_hz  = s_axis_tdata[39:8];
            in_item_next.verbosity_on = s_axis_tdata[40];
            in_valid_next             = 1'b1;
        end else if (proc) begin
            in_valid_next = 1'b0;
        end
    end

    always_comb begin
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        if (proc) begin
            out_next       = step_res;
            out_valid_next = 1'b1;
        end else if (m_axis_tready) begin
            out_valid_next = 1'b0;
        end
    end

    // payload registers carry no reset
    always_ff @(posedge aclk) begin
        in_item_reg <= in_item_next;
        out_reg     <= out_next;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end else begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // ---------------------------------------------------------------
    // Register file and entry logic
    // ---------------------------------------------------------------
    kfe_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .cfg     (cfg)
    );

    kfe_ctrl #(
        .MAX_CHARS (MAX_CHARS)
    ) u_ctrl (
        .aclk    (aclk),
        .aresetn (aresetn),
        .item_en (proc),
        .item    (in_item_reg),
        .cfg     (cfg),
        .result  (step_res)
    );

    // ---------------------------------------------------------------
    // Result packing
    // ---------------------------------------------------------------
    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tdata  = {1'b0, out_reg.freq_hz, out_reg.vfo, out_reg.digit,
                            out_reg.consumed};
    assign m_axis_tuser  = out_reg.event_res;

    // ---------------------------------------------------------------
    // Checks
    // ---------------------------------------------------------------
    // a waiting result must not be overwritten by a new step
    `KFE_ASSERT_NEXT(a_out_hold, aclk, aresetn,
        out_valid_reg && !m_axis_tready,
        out_valid_reg && $stable(out_reg))
    // a buffered transaction must not be dropped while the result side stalls
    `KFE_ASSERT_NEXT(a_in_hold, aclk, aresetn,
        in_valid_reg && !advance,
        in_valid_reg && $stable(in_item_reg))
    // a set request always carries a frequency inside the configured range
    `KFE_ASSERT_NOW(a_set_range, aclk, aresetn,
        out_valid_reg && (out_reg.event_res == EV_SET),
        (out_reg.freq_hz >= cfg.min_freq_hz) && (out_reg.freq_hz <= cfg.max_freq_hz))
    // digit echoes are consumed decimal digits
    `KFE_ASSERT_NOW(a_digit_ok, aclk, aresetn,
        out_valid_reg && (out_reg.event_res == EV_DIGIT),
        out_reg.consumed && (out_reg.digit <= 4'd9))

endmodule

`default_nettype wire
